// File: sv/atrp_pkg.sv
// -----------------------------------------------------------------------------
// atrp_pkg - shared types and constants for the AT response line parser
// Character codes, tag words, event/request codes and the result beat type.
// -----------------------------------------------------------------------------
package atrp_pkg;

  // Default depth of the queue between parser and output stage
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // Event codes
  localparam logic [2:0] EV_NONE      = 3'd0;
  localparam logic [2:0] EV_PAIRED    = 3'd1;
  localparam logic [2:0] EV_CONNECTED = 3'd2;
  localparam logic [2:0] EV_DISCONN   = 3'd3;
  localparam logic [2:0] EV_ERROR     = 3'd4;
  localparam logic [2:0] EV_INIT_DONE = 3'd5;

  // Command requests to the host
  localparam logic [2:0] REQ_NONE     = 3'd0;
  localparam logic [2:0] REQ_NAME     = 3'd1;
  localparam logic [2:0] REQ_SERVICE  = 3'd2;
  localparam logic [2:0] REQ_DISCOVER = 3'd3;
  localparam logic [2:0] REQ_ACCEPT   = 3'd4;

  // Last issued host command
  localparam logic [2:0] CMD_NAME     = 3'd1;
  localparam logic [2:0] CMD_SERVICE  = 3'd2;
  localparam logic [2:0] CMD_DISCOVER = 3'd3;

  // Characters
  localparam logic [7:0] CH_PLUS  = 8'h2B; // '+'
  localparam logic [7:0] CH_E     = 8'h45; // 'E'
  localparam logic [7:0] CH_O     = 8'h4F; // 'O'
  localparam logic [7:0] CH_R     = 8'h52; // 'R'
  localparam logic [7:0] CH_K     = 8'h4B; // 'K'
  localparam logic [7:0] CH_ZERO  = 8'h30; // '0'
  localparam logic [7:0] CH_COMMA = 8'h2C; // ','
  localparam logic [7:0] CH_LF    = 8'h0A; // line feed

  // Tag words, first received byte in the top byte
  localparam logic [31:0] TAG_ERR  = "RR=-";
  localparam logic [31:0] TAG_RSLE = "RSLE";
  localparam logic [31:0] TAG_RCOI = "RCOI";
  localparam logic [31:0] TAG_RCCR = "RCCR";
  localparam logic [31:0] TAG_RDII = "RDII";
  localparam logic [31:0] TAG_RDAI = "RDAI";
  localparam logic [15:0] TAG_OK   = "OK";

  // Tag lengths
  localparam logic [2:0] LEN_TAG4 = 3'd4;
  localparam logic [2:0] LEN_TAG2 = 3'd2;

  // One result beat
  typedef struct packed {
    logic [2:0] event_code;
    logic [7:0] error_digit;
    logic [2:0] command_request;
    logic       ok_seen;
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic       link_connected;
    logic       parser_idle;
  } result_t;

endpackage

// File: sv/atrp_parser.sv
// -----------------------------------------------------------------------------
// atrp_parser - front end: per-byte line parser
// Steps the line state machine on each accepted byte and forms its result.
// -----------------------------------------------------------------------------
module atrp_parser (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step_i,
  input  logic [7:0]       rx_byte_i,
  input  logic [2:0]       issued_command_i,
  output atrp_pkg::result_t res_o
);
  import atrp_pkg::*;

  typedef enum logic [2:0] {
    ST_START = 3'd0,
    ST_ERR   = 3'd1,
    ST_RESP  = 3'd2,
    ST_DATA  = 3'd3,
    ST_OK    = 3'd4,
    ST_ROK   = 3'd5,
    ST_EOL   = 3'd6
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] count_r, count_nxt;   // expected tag length / data field position
  logic [2:0] fill_r, fill_nxt;
  logic [9:0] remain_r, remain_nxt;
  logic       conn_r, conn_nxt;
  logic [7:0] tag_r [4];
  logic       tag_we;

  logic [31:0] tag4;
  logic [15:0] tag2;
  logic        tag_done;
  logic [7:0]  digit;
  logic [6:0]  weight;
  logic [10:0] prod;

  assign tag4     = {tag_r[0], tag_r[1], tag_r[2], tag_r[3]};
  assign tag2     = {tag_r[0], tag_r[1]};
  assign tag_done = !(count_r > fill_r);
  assign digit    = rx_byte_i - CH_ZERO;

  always_comb begin
    case (count_r[1:0])
      2'd0:    weight = 7'd100;
      2'd1:    weight = 7'd10;
      default: weight = 7'd1;
    endcase
  end

  assign prod = 11'(digit[3:0] * weight);

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    fill_nxt   = fill_r;
    remain_nxt = remain_r;
    conn_nxt   = conn_r;
    tag_we     = 1'b0;
    res_o      = '0;

    // tag collection shared by the tag-reading states
    if ((state_r == ST_ERR || state_r == ST_RESP || state_r == ST_ROK) && !tag_done) begin
      tag_we   = 1'b1;
      fill_nxt = fill_r + 3'd1;
    end

    unique case (state_r)
      ST_START: begin
        if (rx_byte_i == CH_PLUS) begin
          state_nxt = ST_RESP;
          count_nxt = LEN_TAG4;
          fill_nxt  = '0;
        end else if (rx_byte_i == CH_E) begin
          state_nxt = ST_ERR;
          count_nxt = LEN_TAG4;
          fill_nxt  = '0;
        end else if (rx_byte_i == CH_O) begin
          state_nxt = ST_OK;
        end else if (rx_byte_i == CH_R) begin
          state_nxt = ST_ROK;
          count_nxt = LEN_TAG2;
          fill_nxt  = '0;
        end
      end
      ST_ROK: begin
        if (tag_done) begin
          if (tag2 == TAG_OK) res_o.command_request = REQ_NAME;
          state_nxt = ST_EOL;
        end
      end
      ST_OK: begin
        if (rx_byte_i == CH_K) begin
          res_o.ok_seen = 1'b1;
          if (issued_command_i == CMD_NAME)         res_o.command_request = REQ_SERVICE;
          else if (issued_command_i == CMD_SERVICE) res_o.command_request = REQ_DISCOVER;
          else if (issued_command_i == CMD_DISCOVER) res_o.event_code     = EV_INIT_DONE;
        end
        state_nxt = ST_EOL;
      end
      ST_ERR: begin
        if (tag_done) begin
          if (tag4 == TAG_ERR) begin
            res_o.error_digit = digit;
            res_o.event_code  = EV_ERROR;
          end
          state_nxt = ST_EOL;
        end
      end
      ST_RESP: begin
        if (tag_done) begin
          state_nxt = ST_EOL;
          if (tag4 == TAG_RSLE) begin
            res_o.event_code = EV_PAIRED;
          end else if (tag4 == TAG_RCOI) begin
            res_o.command_request = REQ_ACCEPT;
          end else if (tag4 == TAG_RCCR) begin
            conn_nxt         = 1'b1;
            res_o.event_code = EV_CONNECTED;
          end else if (tag4 == TAG_RDII) begin
            conn_nxt         = 1'b0;
            res_o.event_code = EV_DISCONN;
          end else if (tag4 == TAG_RDAI) begin
            state_nxt  = ST_DATA;
            count_nxt  = '0;
            remain_nxt = '0;
          end
        end
      end
      ST_DATA: begin
        if (count_r <= 3'd2) begin
          if (digit > 8'd9) state_nxt = ST_START;
          else              remain_nxt = remain_r + prod[9:0];
          count_nxt = count_r + 3'd1;
        end else if (count_r == 3'd3) begin
          count_nxt = count_r + 3'd1;
          if (rx_byte_i != CH_COMMA) state_nxt = ST_START;
          else if (remain_r == '0)   state_nxt = ST_EOL;
        end else if (count_r == 3'd4 && remain_r != '0) begin
          remain_nxt          = remain_r - 10'd1;
          if (remain_r == 10'd1) state_nxt = ST_EOL;
          res_o.payload_valid = 1'b1;
          res_o.payload_byte  = rx_byte_i;
        end else begin
          state_nxt = ST_EOL;
        end
      end
      default: begin
        if (rx_byte_i == CH_LF) state_nxt = ST_START;
      end
    endcase

    res_o.link_connected = conn_nxt;
    res_o.parser_idle    = (state_nxt == ST_START);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_START;
      count_r  <= '0;
      fill_r   <= '0;
      remain_r <= '0;
      conn_r   <= 1'b0;
    end else if (step_i) begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      fill_r   <= fill_nxt;
      remain_r <= remain_nxt;
      conn_r   <= conn_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step_i && tag_we) tag_r[fill_r[1:0]] <= rx_byte_i;
  end

  a_payload_alone: assert property (@(posedge clk) disable iff (!rst_n)
    step_i && res_o.payload_valid |->
      res_o.event_code == EV_NONE && res_o.command_request == REQ_NONE)
    else $error("payload beat carries an event or request");

  a_payload_count: assert property (@(posedge clk) disable iff (!rst_n)
    step_i && state_r == ST_DATA && count_r == 3'd4 && remain_r != '0 |=>
      remain_r == $past(remain_r) - 10'd1)
    else $error("payload count did not step down");

endmodule

// File: sv/atrp_queue.sv
// -----------------------------------------------------------------------------
// atrp_queue - result queue between parser and output stage
// Small register FIFO; no bypass, data out straight from storage.
// -----------------------------------------------------------------------------
module atrp_queue #(
  parameter int unsigned DEPTH = atrp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_i,
  input  atrp_pkg::result_t data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              nempty_o,
  output atrp_pkg::result_t data_o
);
  import atrp_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  result_t       mem [DEPTH];
  logic [PW-1:0] wptr_r, rptr_r;
  logic [CW-1:0] count_r, count_nxt;

  assign full_o   = (count_r == FULL);
  assign nempty_o = (count_r != '0);
  assign data_o   = mem[rptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push_i && !pop_i)      count_nxt = count_r + CW'(1);
    else if (!push_i && pop_i) count_nxt = count_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push_i) wptr_r <= (wptr_r == LAST) ? '0 : wptr_r + PW'(1);
      if (pop_i)  rptr_r <= (rptr_r == LAST) ? '0 : rptr_r + PW'(1);
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) mem[wptr_r] <= data_i;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push_i && full_o))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop_i |-> nempty_o)
    else $error("pop from empty queue");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    push_i && !pop_i |=> count_r == $past(count_r) + CW'(1))
    else $error("queue count lost a push");

endmodule

// File: sv/atrp_out.sv
// -----------------------------------------------------------------------------
// atrp_out - back end: registered result channel
// Drains the queue into an output register and holds it until taken.
// -----------------------------------------------------------------------------
module atrp_out (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              nempty_i,
  input  atrp_pkg::result_t data_i,
  output logic              pop_o,
  output logic              out_valid,
  input  logic              out_ready,
  output atrp_pkg::result_t data_o
);
  import atrp_pkg::*;

  logic    valid_r;
  result_t data_r;

  assign pop_o     = nempty_i && (!valid_r || out_ready);
  assign out_valid = valid_r;
  assign data_o    = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!valid_r || out_ready) begin
      valid_r <= nempty_i;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_o) data_r <= data_i;
  end

endmodule

// File: sv/at_response_line_parser.sv
// -----------------------------------------------------------------------------
// at_response_line_parser - AT link response line parser
// Byte-serial recogniser for OK, ROK, ERR=-d and +R... event/data lines.
// -----------------------------------------------------------------------------
//  channel | direction | ports                                  | beat
//  --------+-----------+----------------------------------------+---------------
//  in      | input     | in_valid/in_ready, in_rx_byte,          | one rx byte
//          |           | in_issued_command                       |
//  out     | output    | out_valid/out_ready, out_event_code ... | one result
//
//  One byte per cycle while the queue is not full; each byte gives exactly
//  one result beat, which is written into the queue and then into the output
//  register.
//  in_ready drops only when the queue is full, i.e. after out_ready has been
//  low long enough for QUEUE_DEPTH beats plus the output register to back up.
//  Reset (rst_n low, synchronous) returns the parser to the line start,
//  clears the connection flag and empties queue and output register.
// -----------------------------------------------------------------------------
module at_response_line_parser #(
  parameter int unsigned QUEUE_DEPTH = atrp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  input  logic [2:0] in_issued_command,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_event_code,
  output logic [7:0] out_error_digit,
  output logic [2:0] out_command_request,
  output logic       out_ok_seen,
  output logic       out_payload_valid,
  output logic [7:0] out_payload_byte,
  output logic       out_link_connected,
  output logic       out_parser_idle
);
  import atrp_pkg::*;

  logic    step;       // input beat accepted
  logic    q_full;
  logic    q_nempty;
  logic    q_pop;
  result_t res;        // result of the byte being stepped
  result_t q_data;     // head of the queue
  result_t out_data;   // held output beat

  assign in_ready = !q_full;
  assign step     = in_valid && in_ready;

  // Front end: line state machine, one byte per step
  atrp_parser u_parser (
    .clk              (clk),
    .rst_n            (rst_n),
    .step_i           (step),
    .rx_byte_i        (in_rx_byte),
    .issued_command_i (in_issued_command),
    .res_o            (res)
  );

  // Decoupling queue
  atrp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_i   (step),
    .data_i   (res),
    .full_o   (q_full),
    .pop_i    (q_pop),
    .nempty_o (q_nempty),
    .data_o   (q_data)
  );

  // Back end: output register
  atrp_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .nempty_i  (q_nempty),
    .data_i    (q_data),
    .pop_o     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .data_o    (out_data)
  );

  assign out_event_code      = out_data.event_code;
  assign out_error_digit     = out_data.error_digit;
  assign out_command_request = out_data.command_request;
  assign out_ok_seen         = out_data.ok_seen;
  assign out_payload_valid   = out_data.payload_valid;
  assign out_payload_byte    = out_data.payload_byte;
  assign out_link_connected  = out_data.link_connected;
  assign out_parser_idle     = out_data.parser_idle;

endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// tb - testbench for at_response_line_parser
// Streams AT response lines byte by byte into the parser and checks every
// result beat against a cycle-free model of the line parser. Both channels
// idle and stall at random. Short and long gaps are mixed, with one calm
// stretch. The sender also holds off until the result queue has drained.
// -----------------------------------------------------------------------------
module tb;
  import atrp_pkg::*;

  // Host commands that the package leaves unnamed
  localparam logic [2:0] CMD_NONE   = 3'd0;
  localparam logic [2:0] CMD_ACCEPT = 3'd4;
  localparam logic [2:0] CMD_RESET  = 3'd5;
  localparam logic [2:0] CMD_SEND   = 3'd6;
  localparam logic [2:0] CMD_LAST   = CMD_SEND;

  // Extra characters used to build lines
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_EQ = 8'h3D;

  localparam int IDLE_LIMIT  = 2000; // cycles without any beat before giving up
  localparam int TAIL_CYCLES = 10;
  localparam int BYTE_TARGET = 1100;

  // ---------------------------------------------------------------------------
  // Line parser model and result store
  // ---------------------------------------------------------------------------
  class line_scoreboard;
    typedef enum logic [2:0] {
      PS_START = 3'd0,
      PS_ERR   = 3'd1,
      PS_RESP  = 3'd2,
      PS_DATA  = 3'd3,
      PS_OK    = 3'd4,
      PS_ROK   = 3'd5,
      PS_EOL   = 3'd6
    } parse_state_t;

    parse_state_t st;
    logic [2:0]   want_len;    // tag length, later the data field position
    logic [2:0]   fill_idx;
    logic [7:0]   tag_buf [4];
    logic [9:0]   pay_left;
    logic         conn;
    logic         err_seen;    // sticky, not visible at the ports

    result_t      expected_q [$];
    int           errors;
    int           checked;
    int           forwarded;
    int           events;

    function new();
      st       = PS_START;
      want_len = '0;
      fill_idx = '0;
      foreach (tag_buf[i]) tag_buf[i] = '0;
      pay_left = '0;
      conn     = 1'b0;
      err_seen = 1'b0;
      errors   = 0;
      checked  = 0;
      forwarded = 0;
      events   = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void open_tag(parse_state_t s, logic [2:0] len);
      st       = s;
      want_len = len;
      fill_idx = '0;
    endfunction

    // Stores the byte while the tag is short; true once the tag is full,
    // in which case this byte is the one that fires the compare.
    function bit tag_complete(logic [7:0] c);
      if (want_len > fill_idx) begin
        tag_buf[fill_idx[1:0]] = c;
        fill_idx = fill_idx + 3'd1;
        return 1'b0;
      end
      return 1'b1;
    endfunction

    function logic [31:0] tag_word();
      return {tag_buf[0], tag_buf[1], tag_buf[2], tag_buf[3]};
    endfunction

    function void note_input(logic [7:0] c, logic [2:0] cmd);
      result_t    r;
      logic [7:0] diff;
      int         weight;
      r = '0;
      case (st)
        PS_START: begin
          if (c == CH_PLUS)   open_tag(PS_RESP, LEN_TAG4);
          else if (c == CH_E) open_tag(PS_ERR, LEN_TAG4);
          else if (c == CH_O) st = PS_OK;
          else if (c == CH_R) open_tag(PS_ROK, LEN_TAG2);
        end
        PS_ROK: begin
          if (tag_complete(c)) begin
            if ({tag_buf[0], tag_buf[1]} == TAG_OK) r.command_request = REQ_NAME;
            st = PS_EOL;
          end
        end
        PS_OK: begin
          if (c == CH_K) begin
            r.ok_seen = 1'b1;
            // init sequence: name -> service -> discoverable -> done
            if (cmd == CMD_NAME)          r.command_request = REQ_SERVICE;
            else if (cmd == CMD_SERVICE)  r.command_request = REQ_DISCOVER;
            else if (cmd == CMD_DISCOVER) r.event_code = EV_INIT_DONE;
          end
          st = PS_EOL;
        end
        PS_ERR: begin
          if (tag_complete(c)) begin
            if (tag_word() == TAG_ERR) begin
              r.error_digit = c - CH_ZERO;
              r.event_code  = EV_ERROR;
              err_seen      = 1'b1;
            end
            st = PS_EOL;
          end
        end
        PS_RESP: begin
          if (tag_complete(c)) begin
            st = PS_EOL;
            if (tag_word() == TAG_RSLE) begin
              r.event_code = EV_PAIRED;
            end else if (tag_word() == TAG_RCOI) begin
              r.command_request = REQ_ACCEPT;
            end else if (tag_word() == TAG_RCCR) begin
              conn = 1'b1;
              r.event_code = EV_CONNECTED;
            end else if (tag_word() == TAG_RDII) begin
              conn = 1'b0;
              r.event_code = EV_DISCONN;
            end else if (tag_word() == TAG_RDAI) begin
              st       = PS_DATA;
              want_len = '0;
              pay_left = '0;
            end
          end
        end
        PS_DATA: begin
          if (want_len <= 3'd2) begin
            // three decimal length digits, hundreds first
            diff = c - CH_ZERO;
            if (diff > 8'd9) begin
              st = PS_START;
            end else begin
              weight   = (want_len == 3'd0) ? 100 : (want_len == 3'd1) ? 10 : 1;
              pay_left = 10'(int'(pay_left) + weight * int'(diff));
            end
            want_len = want_len + 3'd1;
          end else if (want_len == 3'd3) begin
            want_len = want_len + 3'd1;
            if (c != CH_COMMA)       st = PS_START;
            else if (pay_left == '0) st = PS_EOL;
          end else if (want_len == 3'd4 && pay_left != '0) begin
            pay_left = pay_left - 10'd1;
            if (pay_left == '0) st = PS_EOL;
            r.payload_valid = 1'b1;
            r.payload_byte  = c;
          end else begin
            st = PS_EOL;
          end
        end
        default: begin
          if (c == CH_LF) st = PS_START;
        end
      endcase
      r.link_connected = conn;
      r.parser_idle    = (st == PS_START);
      if (r.payload_valid) forwarded++;
      if (r.event_code != EV_NONE) events++;
      expected_q.push_back(r);
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    task cmp_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want)
        report($sformatf("beat %0d %s got %0h want %0h", checked, name, got, want));
    endtask

    task check_result(result_t got);
      result_t want;
      checked++;
      if (expected_q.size() == 0) begin
        report($sformatf("beat %0d arrived with nothing expected", checked));
        return;
      end
      want = expected_q.pop_front();
      cmp_field("event_code", 8'(got.event_code), 8'(want.event_code));
      cmp_field("error_digit", got.error_digit, want.error_digit);
      cmp_field("command_request", 8'(got.command_request), 8'(want.command_request));
      cmp_field("ok_seen", 8'(got.ok_seen), 8'(want.ok_seen));
      cmp_field("payload_valid", 8'(got.payload_valid), 8'(want.payload_valid));
      cmp_field("payload_byte", got.payload_byte, want.payload_byte);
      cmp_field("link_connected", 8'(got.link_connected), 8'(want.link_connected));
      cmp_field("parser_idle", 8'(got.parser_idle), 8'(want.parser_idle));
    endtask
  endclass

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT
  // ---------------------------------------------------------------------------
  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_rx_byte = '0;
  logic [2:0] in_issued_command = CMD_NONE;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [2:0] out_event_code;
  logic [7:0] out_error_digit;
  logic [2:0] out_command_request;
  logic       out_ok_seen;
  logic       out_payload_valid;
  logic [7:0] out_payload_byte;
  logic       out_link_connected;
  logic       out_parser_idle;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  at_response_line_parser DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_rx_byte          (in_rx_byte),
    .in_issued_command   (in_issued_command),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_event_code      (out_event_code),
    .out_error_digit     (out_error_digit),
    .out_command_request (out_command_request),
    .out_ok_seen         (out_ok_seen),
    .out_payload_valid   (out_payload_valid),
    .out_payload_byte    (out_payload_byte),
    .out_link_connected  (out_link_connected),
    .out_parser_idle     (out_parser_idle)
  );

  line_scoreboard sb = new();

  // calm_* switch off idling on that side for a stretch
  bit calm_tx = 1'b0;
  bit calm_rx = 1'b0;

  // Mostly short, occasionally long
  function automatic int short_or_long(int lo_short, int hi_short, int lo_long, int hi_long);
    if ($urandom_range(0, 99) < 88) return $urandom_range(lo_short, hi_short);
    return $urandom_range(lo_long, hi_long);
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure and the checker
  // ---------------------------------------------------------------------------
  int ready_left = 0;

  always @(posedge clk) begin : rx_side
    result_t got;
    if (rst_n && out_valid && out_ready) begin
      got.event_code      = out_event_code;
      got.error_digit     = out_error_digit;
      got.command_request = out_command_request;
      got.ok_seen         = out_ok_seen;
      got.payload_valid   = out_payload_valid;
      got.payload_byte    = out_payload_byte;
      got.link_connected  = out_link_connected;
      got.parser_idle     = out_parser_idle;
      sb.check_result(got);
    end
    // ready and stall periods alternate; ready runs can be long stretches
    if (ready_left > 0) begin
      ready_left = ready_left - 1;
    end else if (calm_rx || !out_ready) begin
      out_ready  <= 1'b1;
      ready_left = calm_rx ? 0 : short_or_long(0, 6, 20, 60);
    end else begin
      out_ready  <= 1'b0;
      ready_left = short_or_long(0, 3, 10, 40);
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: any beat on either channel restarts the count
  // ---------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles = quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no beat for %0d cycles", IDLE_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Byte side: lines are built into a queue, then sent beat by beat
  // ---------------------------------------------------------------------------
  typedef struct {
    logic [7:0] ch;
    logic [2:0] cmd;
  } rx_beat_t;

  rx_beat_t line_q [$];
  int       bytes_sent = 0;
  int       lines_sent = 0;

  function automatic logic [2:0] any_cmd();
    return 3'($urandom_range(0, CMD_LAST));
  endfunction

  task automatic push(logic [7:0] ch, logic [2:0] cmd);
    rx_beat_t b;
    b.ch  = ch;
    b.cmd = cmd;
    line_q.push_back(b);
  endtask

  task automatic push_word(logic [31:0] w, int n);
    for (int i = n - 1; i >= 0; i--) push(w[i*8 +: 8], any_cmd());
  endtask

  // Optional junk ahead of the line end; CR mostly present
  task automatic push_line_end();
    if ($urandom_range(0, 9) < 3)
      repeat ($urandom_range(1, 3)) push(8'($urandom_range(0, 255)), any_cmd());
    if ($urandom_range(0, 9) < 8) push(CH_CR, any_cmd());
    push(CH_LF, any_cmd());
  endtask

  function automatic logic [7:0] non_digit();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b >= CH_ZERO && b <= CH_ZERO + 8'd9);
    return b;
  endfunction

  // A data line, well formed most of the time. Lengths stay small except
  // now and then, since each payload byte costs a beat.
  task automatic push_data_line();
    int         len;
    int         bad_pos;
    logic [7:0] field [4];
    len = ($urandom_range(0, 99) < 2) ? $urandom_range(0, 999) : $urandom_range(0, 12);
    push(CH_PLUS, any_cmd());
    push_word(TAG_RDAI, 4);
    push(($urandom_range(0, 9) < 9) ? CH_EQ : 8'($urandom_range(0, 255)), any_cmd());
    field[0] = CH_ZERO + 8'(len / 100);
    field[1] = CH_ZERO + 8'((len / 10) % 10);
    field[2] = CH_ZERO + 8'(len % 10);
    field[3] = CH_COMMA;
    if ($urandom_range(0, 99) < 15) begin
      bad_pos = $urandom_range(0, 3);
      if (bad_pos == 3) begin
        do field[3] = 8'($urandom_range(0, 255));
        while (field[3] == CH_COMMA);
      end else begin
        field[bad_pos] = non_digit();
      end
    end
    foreach (field[i]) push(field[i], any_cmd());
    repeat (len) push(8'($urandom_range(0, 255)), any_cmd());
    push_line_end();
  endtask

  task automatic push_random_line();
    int          kind;
    logic [31:0] tag;
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      push(CH_O, any_cmd());
      push(CH_K, any_cmd());
      push_line_end();
    end else if (kind < 18) begin
      // reset acknowledge, or an R line with some other two bytes
      push(CH_R, any_cmd());
      if ($urandom_range(0, 9) < 7) push_word({16'h0, TAG_OK}, 2);
      else push_word(32'($urandom), 2);
      push(CH_CR, any_cmd());
      push(CH_LF, any_cmd());
    end else if (kind < 28) begin
      tag = TAG_ERR;
      if ($urandom_range(0, 3) == 0) tag[$urandom_range(0, 3)*8 +: 8] = 8'($urandom);
      push(CH_E, any_cmd());
      push_word(tag, 4);
      push(8'($urandom_range(0, 255)), any_cmd());  // error digit, any byte
      push_line_end();
    end else if (kind < 42) begin
      case ($urandom_range(0, 3))
        0:       tag = TAG_RSLE;
        1:       tag = TAG_RCOI;
        2:       tag = TAG_RCCR;
        default: tag = TAG_RDII;
      endcase
      // tag mismatch now and then, sometimes on a data tag
      if (kind >= 38) begin
        if ($urandom_range(0, 1) == 0) tag = TAG_RDAI;
        tag[$urandom_range(0, 3)*8 +: 8] = 8'($urandom);
      end
      push(CH_PLUS, any_cmd());
      push_word(tag, 4);
      // the byte after the tag fires the compare; leaving it out lets the
      // line feed be swallowed as the compare byte
      if ($urandom_range(0, 9) != 0) push(($urandom_range(0, 1) == 0) ? CH_EQ : CH_CR, any_cmd());
      push_line_end();
    end else if (kind < 80) begin
      push_data_line();
    end else if (kind < 90) begin
      repeat ($urandom_range(1, 6)) push(8'($urandom_range(0, 255)), any_cmd());
      push(CH_LF, any_cmd());
    end else begin
      // O followed by something other than K
      push(CH_O, any_cmd());
      push(($urandom_range(0, 3) == 0) ? CH_LF : 8'($urandom_range(0, 255)), any_cmd());
      push_line_end();
    end
  endtask

  // One beat; on return the beat was accepted at the current edge and
  // in_valid is still high, so back-to-back beats need no second NBA
  task automatic send_byte(logic [7:0] ch, logic [2:0] cmd);
    int gap;
    gap = calm_tx ? 0 : ($urandom_range(0, 99) < 55 ? 0 : short_or_long(1, 3, 8, 30));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_rx_byte        <= ch;
    in_issued_command <= cmd;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(ch, cmd);
    bytes_sent++;
  endtask

  task automatic send_line();
    foreach (line_q[i]) send_byte(line_q[i].ch, line_q[i].cmd);
    line_q.delete();
    lines_sent++;
  endtask

  // Sender holds off until every expected beat has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // OK after set-name: asks for the service command
    push(CH_O, CMD_NONE);
    push(CH_K, CMD_NAME);
    push(CH_LF, CMD_SEND);
    send_line();
    // reset acknowledge
    push(CH_R, CMD_RESET);
    push_word({16'h0, TAG_OK}, 2);
    push(CH_CR, CMD_RESET);
    push(CH_LF, CMD_RESET);
    send_line();
    // error line with the top byte value as its digit
    push(CH_E, CMD_ACCEPT);
    push_word(TAG_ERR, 4);
    push(8'hFF, CMD_ACCEPT);
    push(CH_LF, CMD_ACCEPT);
    send_line();
    // one-byte data line carrying a zero byte
    push(CH_PLUS, CMD_SEND);
    push_word(TAG_RDAI, 4);
    push(CH_EQ, CMD_SEND);
    push(CH_ZERO, CMD_SEND);
    push(CH_ZERO, CMD_SEND);
    push(CH_ZERO + 8'd1, CMD_SEND);
    push(CH_COMMA, CMD_SEND);
    push(8'h00, CMD_SEND);
    push(CH_LF, CMD_SEND);
    send_line();
    drain();

    // random lines in four phases; the third runs with no idling at all
    for (int phase = 0; phase < 4; phase++) begin
      calm_tx = (phase == 2);
      calm_rx = (phase == 2);
      while (bytes_sent < (phase + 1) * (BYTE_TARGET / 4)) begin
        push_random_line();
        send_line();
      end
      drain();
    end
    calm_tx = 1'b0;
    calm_rx = 1'b0;

    // anything arriving now is an extra beat
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d lines, %0d bytes, %0d result beats checked,", lines_sent,
             bytes_sent, sb.checked);
    $display("  %0d events and %0d payload bytes forwarded, %0d mismatches", sb.events,
             sb.forwarded, sb.errors);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
